### sv/arqt_pkg.sv
package arqt_pkg;

    // Request kinds
    localparam logic REQ_RECV = 1'b0;
    localparam logic REQ_SEND = 1'b1;

    // Result status codes
    localparam logic [1:0] STS_ACCEPTED = 2'd0;
    localparam logic [1:0] STS_OLD_DUP  = 2'd1;
    localparam logic [1:0] STS_BEYOND   = 2'd2;
    localparam logic [1:0] STS_SENT     = 2'd3;

    localparam logic [15:0] HOLDOFF_RESET = 16'd100;
    localparam int          NAK_SAT       = 255;
    localparam int          REL_SAT       = 127;

    typedef struct packed {
        logic              req_type;
        logic [30:0]       packet_num;
        logic signed [31:0] ack_num;
        logic [7:0]        nak_count;
        logic [31:0]       now_ms;
    } arqt_in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [6:0]        released_count;
        logic              resend_valid;
        logic [30:0]       resend_first;
        logic [30:0]       resend_last;
        logic              nak_invalid;
        logic [30:0]       assigned_seq;
        logic signed [31:0] hdr_ack;
        logic [7:0]        hdr_nak;
    } arqt_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REL,
        ST_GAP
    } arqt_state_t;

    typedef struct packed {
        logic take_en;
        logic rel_en;
        logic load_en;
    } arqt_cmd_t;

    typedef struct packed {
        logic out_free;
    } arqt_sts_t;

endpackage

### sv/arqt_ctrl.sv
module arqt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  arqt_pkg::arqt_sts_t sts,
    output arqt_pkg::arqt_cmd_t cmd
);
    import arqt_pkg::*;

    arqt_state_t state_reg;
    arqt_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.take_en = s_valid;
                if (s_valid) begin
                    state_next = ST_REL;
                end
            end
            ST_REL: begin
                cmd.rel_en = 1'b1;
                state_next = ST_GAP;
            end
            ST_GAP: begin
                // Finish this word and take the next one on the same edge
                if (sts.out_free) begin
                    cmd.load_en = 1'b1;
                    s_ready     = 1'b1;
                    cmd.take_en = s_valid;
                    state_next  = s_valid ? ST_REL : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/arqt_dpath.sv
module arqt_dpath #(
    parameter int WINDOW = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  arqt_pkg::arqt_in_t  s_data,
    input  arqt_pkg::arqt_cmd_t cmd,
    output arqt_pkg::arqt_sts_t sts,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    output logic                m_valid,
    input  logic                m_ready,
    output arqt_pkg::arqt_out_t m_data
);
    import arqt_pkg::*;

    localparam int BW = $clog2(WINDOW);
    localparam int CW = $clog2(WINDOW + 1);

    // Link state
    logic signed [31:0] lio_reg;
    logic [WINDOW-1:0]  map_reg;
    logic [BW-1:0]      base_reg;       // slot of lio_reg + 1
    logic [30:0]        oldest_reg;
    logic [30:0]        nseq_reg;
    logic signed [31:0] last_nak_reg;
    logic [31:0]        stamp_reg;
    logic [15:0]        holdoff_reg;

    // Per-word working registers
    logic               req_reg;
    logic [7:0]         nak_reg;
    logic [31:0]        now_reg;
    logic [1:0]         status_reg;
    logic [30:0]        assigned_reg;
    logic [6:0]         released_reg;
    logic               rvalid_reg;
    logic [30:0]        rfirst_reg;
    logic [30:0]        rlast_reg;
    logic               ninv_reg;

    arqt_out_t          out_reg;
    arqt_out_t          out_next;
    logic               out_valid_reg;

    // Intake: classify the header and retire acked packets
    logic [32:0]        lio33;
    logic [32:0]        pnum33;
    logic [32:0]        diff33;
    logic               is_old;
    logic               is_beyond;
    logic [BW:0]        slot_sum;
    logic [BW-1:0]      take_slot;
    logic               is_dup;
    logic [32:0]        ack33;
    logic [32:0]        lim33;
    logic               ack_adv;
    logic [30:0]        oldest_next;

    always_comb begin
        lio33     = {lio_reg[31], lio_reg};
        pnum33    = {2'b00, s_data.packet_num};
        diff33    = pnum33 - lio33 - 33'd1;
        is_old    = $signed(lio33) >= $signed(pnum33);
        is_beyond = !is_old && (diff33 >= 33'(WINDOW));
        slot_sum  = {1'b0, base_reg} + {1'b0, diff33[BW-1:0]};
        if (slot_sum >= (BW+1)'(WINDOW)) begin
            slot_sum = slot_sum - (BW+1)'(WINDOW);
        end
        take_slot = slot_sum[BW-1:0];
        is_dup    = map_reg[take_slot];

        ack33   = {s_data.ack_num[31], s_data.ack_num};
        lim33   = ack33 + 33'd1;
        ack_adv = ($signed(ack33) >= $signed({2'b00, oldest_reg})) && (oldest_reg < nseq_reg);
        if ($signed(lim33) > $signed({2'b00, nseq_reg})) begin
            oldest_next = nseq_reg;
        end else begin
            oldest_next = lim33[30:0];
        end
    end

    // Release: run of set slots from lio + 1
    logic [2*WINDOW-1:0] dbl;
    logic [WINDOW-1:0]   rot;
    logic [CW-1:0]       cnt;
    logic [WINDOW-1:0]   map_next;
    logic [CW:0]         bsum;
    logic [BW-1:0]       base_next;
    logic signed [31:0]  lio_next;
    logic [6:0]          released_next;

    always_comb begin
        logic [BW:0] offs;
        dbl = {map_reg, map_reg} >> base_reg;
        rot = dbl[WINDOW-1:0];
        cnt = CW'(WINDOW);
        for (int i = WINDOW - 1; i >= 0; i--) begin
            if (!rot[i]) begin
                cnt = CW'(i);
            end
        end
        for (int i = 0; i < WINDOW; i++) begin
            offs = (BW+1)'(i) + (BW+1)'(WINDOW) - {1'b0, base_reg};
            if (offs >= (BW+1)'(WINDOW)) begin
                offs = offs - (BW+1)'(WINDOW);
            end
            map_next[i] = map_reg[i] && !(32'(offs) < 32'(cnt));
        end
        bsum = (CW+1)'(base_reg) + (CW+1)'(cnt);
        if (bsum >= (CW+1)'(WINDOW)) begin
            bsum = bsum - (CW+1)'(WINDOW);
        end
        base_next = bsum[BW-1:0];
        lio_next  = lio_reg + $signed(32'(cnt));
        if (32'(cnt) > 32'(REL_SAT)) begin
            released_next = 7'(REL_SAT);
        end else begin
            released_next = 7'(cnt);
        end
    end

    // NAK to resend range, using the oldest unacked number after retiring
    logic [32:0] nak_abs33;
    logic        nak_upd;
    logic        ninv_next;

    always_comb begin
        nak_abs33 = {25'd0, nak_reg} + {2'b00, oldest_reg} - 33'd1;
        nak_upd   = 1'b0;
        ninv_next = 1'b0;
        if (req_reg == REQ_RECV && nak_reg != 8'd0) begin
            if (nak_abs33 >= {2'b00, nseq_reg}) begin
                ninv_next = 1'b1;
            end else if (nak_abs33[31:0] != last_nak_reg ||
                         (now_reg - stamp_reg) > {16'd0, holdoff_reg}) begin
                nak_upd = 1'b1;
            end
        end
    end

    // Gap to the first waiting packet for the outgoing header
    logic [2*WINDOW-1:0] dbl_gap;
    logic [WINDOW-1:0]   rot_gap;
    logic [BW-1:0]       gap;

    always_comb begin
        dbl_gap = {map_reg, map_reg} >> base_reg;
        rot_gap = dbl_gap[WINDOW-1:0];
        gap     = '0;
        for (int i = WINDOW - 1; i >= 1; i--) begin
            if (rot_gap[i]) begin
                gap = BW'(i);
            end
        end
        out_next.status         = status_reg;
        out_next.released_count = released_reg;
        out_next.resend_valid   = rvalid_reg;
        out_next.resend_first   = rfirst_reg;
        out_next.resend_last    = rlast_reg;
        out_next.nak_invalid    = ninv_reg;
        out_next.assigned_seq   = assigned_reg;
        out_next.hdr_ack        = lio_reg;
        if (32'(gap) > 32'(NAK_SAT)) begin
            out_next.hdr_nak = 8'(NAK_SAT);
        end else begin
            out_next.hdr_nak = 8'(gap);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lio_reg       <= -32'sd1;
            map_reg       <= '0;
            base_reg      <= '0;
            oldest_reg    <= '0;
            nseq_reg      <= '0;
            last_nak_reg  <= -32'sd1;
            stamp_reg     <= '0;
            holdoff_reg   <= HOLDOFF_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                holdoff_reg <= cfg_wr_data;
            end
            if (cmd.take_en) begin
                if (s_data.req_type == REQ_SEND) begin
                    nseq_reg <= nseq_reg + 31'd1;
                end else begin
                    if (ack_adv) begin
                        oldest_reg <= oldest_next;
                    end
                    if (!is_old && !is_beyond && !is_dup) begin
                        map_reg[take_slot] <= 1'b1;
                    end
                end
            end
            if (cmd.rel_en) begin
                map_reg  <= map_next;
                base_reg <= base_next;
                lio_reg  <= lio_next;
                if (nak_upd) begin
                    last_nak_reg <= nak_abs33[31:0];
                    stamp_reg    <= now_reg;
                end
            end
            if (cmd.load_en) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_en) begin
            req_reg <= s_data.req_type;
            nak_reg <= s_data.nak_count;
            now_reg <= s_data.now_ms;
            if (s_data.req_type == REQ_SEND) begin
                status_reg   <= STS_SENT;
                assigned_reg <= nseq_reg;
            end else begin
                assigned_reg <= '0;
                if (is_old) begin
                    status_reg <= STS_OLD_DUP;
                end else if (is_beyond) begin
                    status_reg <= STS_BEYOND;
                end else if (is_dup) begin
                    status_reg <= STS_OLD_DUP;
                end else begin
                    status_reg <= STS_ACCEPTED;
                end
            end
        end
        if (cmd.rel_en) begin
            released_reg <= released_next;
            ninv_reg     <= ninv_next;
            rvalid_reg   <= nak_upd;
            rfirst_reg   <= nak_upd ? oldest_reg : 31'd0;
            rlast_reg    <= nak_upd ? nak_abs33[30:0] : 31'd0;
        end
        if (cmd.load_en) begin
            out_reg <= out_next;
        end
    end

    assign sts.out_free = !out_valid_reg || m_ready;
    assign m_valid      = out_valid_reg;
    assign m_data       = out_reg;

endmodule

### sv/arq_sequence_ack_nak_tracker_unit.sv
// Selective-repeat ARQ header tracker.
// Input channel (s_valid/s_ready/s_data): one word per received packet
// header or per new packet sent. Result channel (m_valid/m_ready/m_data):
// exactly one word per input word, in order, carrying the status, the
// released count, any resend range and the outgoing header fields.
// Config: cfg_wr_en/cfg_wr_data write the NAK holdoff in ms at any edge;
// write it only while the block is idle.
// Order: a word is taken, then goes through the release state and the gap
// state, where its result is loaded; the release step (priority search and
// clear over the arrival bitmap) and the header gap search are separate
// states, and the next word is taken in the gap state.
// Stall: the result register holds while m_ready is low; one more word is
// taken and worked up to the gap state, then s_ready stays low until the
// held result is taken.
// Reset (aresetn low, synchronous): last in-order number -1, bitmap clear,
// sequence counters zero, NAK memory cleared, holdoff back to 100 ms,
// no result pending; s_ready is high on the first cycle after reset.
module arq_sequence_ack_nak_tracker_unit #(
    parameter int WINDOW = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  arqt_pkg::arqt_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output arqt_pkg::arqt_out_t m_data,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data
);
    import arqt_pkg::*;

    arqt_cmd_t cmd;
    arqt_sts_t sts;

    // Sequence the word: take, release, gap and load
    arqt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Hold link state, bitmap and the result register
    arqt_dpath #(
        .WINDOW (WINDOW)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

### sv/arqt_chk.sv
module arqt_chk (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input arqt_pkg::arqt_out_t m_data
);
    import arqt_pkg::*;

    // Leave reset idle and ready
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("not idle after reset");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // Drop ready for the release cycle after every accepted word
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("word accepted back to back");

    // Keep send results free of receive fields
    a_send_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STS_SENT |->
            !m_data.resend_valid && !m_data.nak_invalid && m_data.released_count == 7'd0)
        else $error("send result carries receive fields");

    // Keep resend ranges ordered and apart from invalid NAKs
    a_resend_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.resend_valid |->
            !m_data.nak_invalid && m_data.resend_first <= m_data.resend_last)
        else $error("bad resend range");

endmodule

bind arq_sequence_ack_nak_tracker_unit arqt_chk u_arqt_chk (.*);

### tb/arq_tracker_checker.sv
`timescale 1ns / 100ps

module arq_tracker_checker #(
    parameter int WINDOW = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  arqt_pkg::arqt_in_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  arqt_pkg::arqt_out_t m_data,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    output int                  mismatch_count,
    output int                  results_owed
);

    import arqt_pkg::*;

    // Tracker state, kept in step with every accepted word
    longint            in_order;
    logic [WINDOW-1:0] arrived;
    logic [30:0]       oldest_unacked;
    logic [30:0]       next_seq;
    longint            last_nak_abs;
    logic [31:0]       last_nak_stamp;
    logic [15:0]       holdoff_ms;

    arqt_out_t         owed_q[$];
    arqt_out_t         want;

    function automatic int slot_of(longint seq);
        return int'(seq % WINDOW);
    endfunction

    // Advance the tracker by one word and return the header result it yields.
    function automatic arqt_out_t track_word(arqt_in_t w);
        arqt_out_t   r;
        longint      pnum;
        longint      ack;
        longint      lim;
        longint      nak_abs;
        longint      oldest_l;
        longint      next_l;
        logic [31:0] elapsed;
        int          d;

        r = '0;
        if (w.req_type == REQ_SEND) begin
            r.assigned_seq = next_seq;
            next_seq = next_seq + 31'd1;
            r.status = STS_SENT;
        end else begin
            pnum = longint'(w.packet_num);
            ack = longint'($signed(w.ack_num));
            oldest_l = longint'(oldest_unacked);
            next_l = longint'(next_seq);

            // retire acked packets, never past what was sent
            if (ack >= oldest_l && oldest_l < next_l) begin
                lim = (ack + 1 > next_l) ? next_l : ack + 1;
                oldest_unacked = lim[30:0];
                oldest_l = lim;
            end

            if (w.nak_count != 8'd0) begin
                nak_abs = longint'(w.nak_count) + oldest_l - 1;
                elapsed = w.now_ms - last_nak_stamp;
                if (nak_abs >= next_l) begin
                    r.nak_invalid = 1'b1;
                end else if (nak_abs != last_nak_abs || elapsed > {16'd0, holdoff_ms}) begin
                    last_nak_abs = nak_abs;
                    last_nak_stamp = w.now_ms;
                    r.resend_valid = 1'b1;
                    r.resend_first = oldest_unacked;
                    r.resend_last = nak_abs[30:0];
                end
            end

            if (in_order >= pnum) begin
                r.status = STS_OLD_DUP;
            end else if (pnum - in_order - 1 >= WINDOW) begin
                r.status = STS_BEYOND;
            end else if (arrived[slot_of(pnum)]) begin
                r.status = STS_OLD_DUP;
            end else begin
                r.status = STS_ACCEPTED;
                arrived[slot_of(pnum)] = 1'b1;
                while (arrived[slot_of(in_order + 1)]) begin
                    arrived[slot_of(in_order + 1)] = 1'b0;
                    in_order++;
                    if (r.released_count < REL_SAT)
                        r.released_count = r.released_count + 7'd1;
                end
            end
        end

        r.hdr_ack = in_order[31:0];
        for (d = 1; d < WINDOW; d++) begin
            if (arrived[slot_of(in_order + 1 + d)]) begin
                r.hdr_nak = (d > NAK_SAT) ? 8'(NAK_SAT) : 8'(d);
                break;
            end
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            in_order = -1;
            arrived = '0;
            oldest_unacked = '0;
            next_seq = '0;
            last_nak_abs = -1;
            last_nak_stamp = '0;
            holdoff_ms = HOLDOFF_RESET;
            owed_q.delete();
        end else begin
            if (cfg_wr_en)
                holdoff_ms = cfg_wr_data;

            // compare before queuing so a same-edge input cannot mask a stray result
            if (m_valid && m_ready) begin
                if (owed_q.size() == 0) begin
                    $display("%0t: result word with none outstanding, actual %h",
                             $time, m_data);
                    mismatch_count++;
                end else begin
                    want = owed_q[0];
                    owed_q.delete(0);
                    check_field("status", want.status, m_data.status);
                    check_field("released_count", want.released_count, m_data.released_count);
                    check_field("resend_valid", want.resend_valid, m_data.resend_valid);
                    check_field("resend_first", want.resend_first, m_data.resend_first);
                    check_field("resend_last", want.resend_last, m_data.resend_last);
                    check_field("nak_invalid", want.nak_invalid, m_data.nak_invalid);
                    check_field("assigned_seq", want.assigned_seq, m_data.assigned_seq);
                    check_field("hdr_ack", want.hdr_ack, m_data.hdr_ack);
                    check_field("hdr_nak", want.hdr_nak, m_data.hdr_nak);
                end
            end

            if (s_valid && s_ready)
                owed_q.insert(owed_q.size(), track_word(s_data));
        end
        results_owed = owed_q.size();
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import arqt_pkg::*;

    localparam int WINDOW      = 64;
    localparam int QUIET_LIMIT = 4000;   // cycles with no word moving on either side
    localparam int PHASE_WORDS = 250;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    arqt_in_t    s_data;
    logic        m_valid;
    logic        m_ready;
    arqt_out_t   m_data;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    int          mismatch_count;
    int          results_owed;
    int          quiet_cycles = 0;

    // Peer model used only to shape stimulus: how many packets we have sent,
    // how far the peer has acked, and which receive numbers come next.
    int          tx_sent   = 0;
    int          peer_ack  = -1;
    int          rx_base   = 0;
    int          last_nak  = 0;
    logic [31:0] wall_ms   = '0;
    bit          s_calm    = 1'b0;
    int          rx_plan[$];
    int          rx_late[$];

    // 20 ns period
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    arq_sequence_ack_nak_tracker_unit #(
        .WINDOW (WINDOW)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    arq_tracker_checker #(
        .WINDOW (WINDOW)
    ) chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // Build a received-header word; also move the wall clock to its time.
    function automatic arqt_in_t hdr_word(int pnum, int ack, int nak, logic [31:0] t);
        arqt_in_t w;
        w.req_type   = REQ_RECV;
        w.packet_num = pnum[30:0];
        w.ack_num    = ack;
        w.nak_count  = nak[7:0];
        w.now_ms     = t;
        wall_ms      = t;
        return w;
    endfunction

    // Send word: the header fields are don't-care, so fill them with junk.
    function automatic arqt_in_t send_word();
        arqt_in_t    w;
        logic [31:0] a;
        logic [31:0] b;
        a = $urandom();
        b = $urandom();
        w.req_type   = REQ_SEND;
        w.packet_num = a[30:0];
        w.ack_num    = b;
        w.nak_count  = a[31:24] ^ b[7:0];
        w.now_ms     = $urandom();
        tx_sent++;
        return w;
    endfunction

    // Mostly a cumulative ack that creeps toward what was sent; sometimes
    // none, stale, past the end, or anywhere in range.
    function automatic int pick_ack();
        int r;
        int step_max;
        r = $urandom_range(0, 99);
        if (r < 8)
            return -1;
        if (r < 70) begin
            step_max = tx_sent - 1 - peer_ack;
            if (step_max > 4)
                step_max = 4;
            if (step_max > 0 && $urandom_range(0, 1) == 1)
                peer_ack += $urandom_range(1, step_max);
            return peer_ack;
        end
        if (r < 85)
            return int'($urandom_range(0, tx_sent)) - 1;
        if (r < 95)
            return tx_sent + $urandom_range(0, 20);
        return int'($urandom() & 32'h7FFF_FFFF);
    endfunction

    // Mostly no NAK or one inside what was sent; repeat the last one often
    // enough to hit the holdoff, and now and then overshoot.
    function automatic int pick_nak();
        int r;
        int room;
        r = $urandom_range(0, 99);
        room = tx_sent - peer_ack - 1;
        if (r < 50)
            return 0;
        if (r < 80)
            last_nak = $urandom_range(1, (room < 1) ? 1 : ((room > 255) ? 255 : room));
        else if (r < 92)
            ;
        else if (r < 96)
            last_nak = NAK_SAT;
        else
            last_nak = $urandom_range(0, 255);
        return last_nak;
    endfunction

    function automatic logic [31:0] tick_ms();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            wall_ms = wall_ms + $urandom_range(0, 20);
        else if (r < 85)
            wall_ms = wall_ms + $urandom_range(0, 150);
        else if (r < 97)
            wall_ms = wall_ms + $urandom_range(100, 70000);
        else
            wall_ms = $urandom();
        return wall_ms;
    endfunction

    // Queue the next block of fresh receive numbers in shuffled order.
    // Late stragglers from the previous block go out first so the in-order
    // point catches up before the new block lands. A rare full-window block
    // holds its lowest number back to the end to release the whole window.
    function automatic void refill_plan();
        int blk[WINDOW];
        int k;
        int i;
        int j;
        int t;
        while (rx_late.size() != 0) begin
            rx_plan.insert(rx_plan.size(), rx_late[0]);
            rx_late.delete(0);
        end
        k = ($urandom_range(0, 99) < 4) ? WINDOW : $urandom_range(1, 12);
        for (i = 0; i < k; i++)
            blk[i] = rx_base + i;
        for (i = k - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = blk[i];
            blk[i] = blk[j];
            blk[j] = t;
        end
        if (k == WINDOW) begin
            for (i = 0; i < k; i++) begin
                if (blk[i] == rx_base) begin
                    blk[i] = blk[k - 1];
                    blk[k - 1] = rx_base;
                end
            end
        end
        j = (k > 1 && k < WINDOW && $urandom_range(0, 99) < 15) ? $urandom_range(0, k - 1) : -1;
        for (i = 0; i < k; i++) begin
            if (i == j)
                rx_late.insert(rx_late.size(), blk[i]);
            else
                rx_plan.insert(rx_plan.size(), blk[i]);
        end
        rx_base += k;
    endfunction

    // Receive word: mostly the planned stream, the rest old numbers,
    // numbers past the window, and random numbers.
    function automatic arqt_in_t recv_word();
        int r;
        int pnum;
        int span;
        r = $urandom_range(0, 99);
        if (r < 5 && rx_base > 0) begin
            span = (rx_base > 80) ? 80 : rx_base;
            pnum = rx_base - 1 - $urandom_range(0, span - 1);
        end else if (r < 9) begin
            pnum = rx_base + WINDOW + $urandom_range(0, 300);
        end else if (r < 11) begin
            pnum = int'($urandom() & 32'h7FFF_FFFF);
        end else begin
            if (rx_plan.size() == 0)
                refill_plan();
            pnum = rx_plan[0];
            rx_plan.delete(0);
        end
        return hdr_word(pnum, pick_ack(), pick_nak(), tick_ms());
    endfunction

    function automatic int pick_gap();
        int r;
        if (s_calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Drive one word: idle for a random gap, then hold valid and payload
    // until the handshake. Valid stays high into the next word when the
    // next gap is zero.
    task automatic drive_word(arqt_in_t w);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= w;
        do
            @(posedge aclk);
        while (!s_ready);
    endtask

    // Drop valid and wait for every owed result, then let the pipeline drain.
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (results_owed != 0)
            @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic write_holdoff(logic [15:0] v);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Result side back-pressure: runs of ready with short or long stalls,
    // and some runs with no stall at all.
    initial begin
        int run;
        int stall;
        m_ready = 1'b0;
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
            repeat (run) begin
                @(negedge aclk);
                m_ready <= 1'b1;
            end
            stall = ($urandom_range(0, 99) < 75) ? $urandom_range(1, 3) : $urandom_range(10, 60);
            repeat (stall) begin
                @(negedge aclk);
                m_ready <= 1'b0;
            end
        end
    end

    // Watchdog: give up when nothing moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [15:0] holdoffs[5];
        int          p;
        int          i;

        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;

        holdoffs[0] = 16'd0;
        holdoffs[1] = 16'hFFFF;
        holdoffs[2] = 16'($urandom_range(1, 300));
        holdoffs[3] = HOLDOFF_RESET;
        holdoffs[4] = 16'($urandom_range(0, 65535));

        // hold reset, then release it on a falling edge
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed opening, holdoff still at its reset value.
        drive_word(hdr_word(0, -1, 0, 32'd1000));          // first packet in order
        drive_word(send_word());
        drive_word(send_word());
        drive_word(send_word());                           // sent 0..2
        drive_word(hdr_word(0, 0, 1, 32'd1010));           // old packet, first resend
        drive_word(hdr_word(2, 0, 1, 32'd1050));           // same NAK inside holdoff
        drive_word(hdr_word(2, 0, 1, 32'd1151));           // same NAK after holdoff, dup
        drive_word(hdr_word(70, 0, 5, 32'd1160));          // NAK past sent, beyond window
        drive_word(hdr_word(65, 0, 2, 32'd1170));          // exactly one past the window
        drive_word(hdr_word(64, 0, 0, 32'd1180));          // last slot of the window
        drive_word(hdr_word(1, 32'h7FFF_FFFF, 2, 32'd1190)); // ack clamps, releases two
        drive_word(hdr_word(32'h7FFF_FFFF, -1, 255, 32'd1200));
        drive_word(send_word());
        drive_word(send_word());                           // sent 3..4
        drive_word(hdr_word(1, 3, 1, 32'hFFFF_FFF0));      // fresh NAK just before wrap
        drive_word(hdr_word(2, 3, 1, 32'h0000_0010));      // repeat across time wrap
        drive_word(hdr_word(3, 3, 1, 32'h0000_0060));      // repeat after holdoff
        drive_word(send_word());
        drive_word(send_word());

        // hand the generator a stream that lines up with the directed part
        peer_ack = 3;
        rx_base  = 4;

        // Random phases, each under a different holdoff.
        for (p = 0; p < 5; p++) begin
            settle();
            write_holdoff(holdoffs[p]);
            for (i = 0; i < PHASE_WORDS; i++) begin
                if ($urandom_range(0, 79) == 0)
                    s_calm = !s_calm;
                if ($urandom_range(0, 99) < 30)
                    drive_word(send_word());
                else
                    drive_word(recv_word());
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
